/* src/ole_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg
// Shared sizes, opcodes, status codes and controller/datapath link types
// for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int DEPTH       = 32;
    localparam int TOKEN_WIDTH = 16;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W    = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

    localparam int S_FIELDS_W = OP_W + TOKEN_WIDTH + POS_W;
    localparam int M_FIELDS_W = STATUS_W + TOKEN_WIDTH + COUNT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_FRONT  = 3'd0,
        OP_BACK   = 3'd1,
        OP_POS    = 3'd2,
        OP_DEL    = 3'd3,
        OP_RD_FWD = 3'd4,
        OP_RD_REV = 3'd5
    } ole_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_NOPOS    = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5
    } ole_status_t;

    typedef struct packed {
        logic        latch;
        logic        addr_load;
        logic        addr_step;
        logic        rd_en;
        logic        scan_en;
        logic        put_wr;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        out_load;
        logic        out_mem;
        ole_status_t out_status;
    } ole_ctl_t;

    typedef struct packed {
        ole_op_t op;
        logic    empty;
        logic    full;
        logic    pos_zero;
        logic    pos_beyond;
        logic    has_moves;
        logic    addr_last;
        logic    rd_last;
        logic    found;
        logic    out_free;
    } ole_sts_t;

endpackage

/* src/ordered_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered token list with front, back and positional insert, delete by
// value, and forward or reverse readout.
// Sequence: a rejected command goes from decode straight to its status item;
//   an insert with no entries to move writes its token without a walk; other
//   inserts and every delete walk the memory, one entry per cycle.
// Throughput: one command at a time; reads stream one entry per cycle while
//   the output accepts, after a first read on the memory's single registered port.
// Reset: fill count goes to zero, output empties; memory contents are kept.
// ----------------------------------------------------------------------------
module ordered_list_engine
    import ole_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // cmd, token_in, position
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // status, token_out, entry_count
    output logic                 m_tlast
);

    ole_ctl_t ctl;
    ole_sts_t sts;

    ole_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    ole_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .ctl      (ctl),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* src/ole_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_dp
// Datapath: entry memory, fill count, scan address, match logic and the
// output item register.
// ----------------------------------------------------------------------------
module ole_dp
    import ole_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  ole_ctl_t             ctl,
    output ole_sts_t             sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic [TOKEN_WIDTH-1:0] mem [DEPTH];

    ole_op_t                op_reg;
    logic [TOKEN_WIDTH-1:0] tok_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [COUNT_W-1:0]     idx_reg;
    logic [COUNT_W-1:0]     cnt_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [ADDR_W-1:0]      rd_addr_reg;
    logic [TOKEN_WIDTH-1:0] rdata_reg;
    logic                   rvalid_reg;
    logic                   found_reg;

    logic                   m_valid_reg;
    ole_status_t            m_status_reg;
    logic [TOKEN_WIDTH-1:0] m_token_reg;
    logic                   m_last_reg;
    logic [COUNT_W-1:0]     m_count_reg;

    ole_op_t                op_in;
    logic [TOKEN_WIDTH-1:0] tok_in;
    logic [POS_W-1:0]       pos_in;
    logic [COUNT_W-1:0]     idx_in;
    logic                   is_ins;
    logic                   step_down;
    logic                   out_free;
    logic                   match;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [TOKEN_WIDTH-1:0] wr_data;

    assign op_in  = ole_op_t'(s_tdata[OP_W-1:0]);
    assign tok_in = s_tdata[OP_W +: TOKEN_WIDTH];
    assign pos_in = s_tdata[OP_W+TOKEN_WIDTH +: POS_W];

    always_comb begin
        case (op_in)
            OP_FRONT: idx_in = '0;
            OP_BACK:  idx_in = cnt_reg;
            default:  idx_in = COUNT_W'(CMP_W'(pos_in) - CMP_W'(1));
        endcase
    end

    assign is_ins    = op_reg inside {OP_FRONT, OP_BACK, OP_POS};
    assign step_down = is_ins || (op_reg == OP_RD_REV);
    assign out_free  = !m_valid_reg || m_tready;
    assign match     = (rdata_reg == tok_reg);

    // write port: token write and shift up on insert, shift down after the match on delete
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rd_addr_reg;
        wr_data = rdata_reg;
        if (ctl.put_wr) begin
            wr_en   = 1'b1;
            wr_addr = idx_reg[ADDR_W-1:0];
            wr_data = tok_reg;
        end else if (ctl.scan_en && rvalid_reg) begin
            if (is_ins) begin
                wr_en   = 1'b1;
                wr_addr = rd_addr_reg + 1'b1;
            end else if (found_reg) begin
                wr_en   = 1'b1;
                wr_addr = rd_addr_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rdata_reg   <= mem[addr_reg];
            rd_addr_reg <= addr_reg;
        end
        if (ctl.latch) begin
            op_reg  <= op_in;
            tok_reg <= tok_in;
            pos_reg <= pos_in;
            idx_reg <= idx_in;
        end
        if (ctl.addr_load) begin
            if (is_ins || op_reg == OP_RD_REV) begin
                addr_reg <= ADDR_W'(cnt_reg - 1'b1);
            end else begin
                addr_reg <= '0;
            end
        end else if (ctl.addr_step) begin
            addr_reg <= step_down ? addr_reg - 1'b1 : addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else begin
            rvalid_reg <= ctl.rd_en;
            if (ctl.cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (ctl.cnt_dec) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (ctl.latch) begin
                found_reg <= 1'b0;
            end else if (ctl.scan_en && rvalid_reg && !is_ins && match) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_count_reg <= cnt_reg;
            if (ctl.out_mem) begin
                m_status_reg <= ST_OK;
                m_token_reg  <= rdata_reg;
                m_last_reg   <= sts.rd_last;
            end else begin
                m_status_reg <= ctl.out_status;
                m_token_reg  <= '0;
                m_last_reg   <= 1'b1;
            end
        end
    end

    always_comb begin
        sts.op         = op_reg;
        sts.empty      = (cnt_reg == '0);
        sts.full       = (CMP_W'(cnt_reg) == CMP_W'(DEPTH));
        sts.pos_zero   = (pos_reg == '0);
        sts.pos_beyond = (CMP_W'(pos_reg) > (CMP_W'(cnt_reg) + CMP_W'(1)));
        sts.has_moves  = (cnt_reg > idx_reg);
        if (is_ins) begin
            sts.addr_last = (CMP_W'(addr_reg) == CMP_W'(idx_reg));
        end else begin
            sts.addr_last = ((CMP_W'(addr_reg) + CMP_W'(1)) == CMP_W'(cnt_reg));
        end
        if (op_reg == OP_RD_REV) begin
            sts.rd_last = (rd_addr_reg == '0);
        end else begin
            sts.rd_last = ((CMP_W'(rd_addr_reg) + CMP_W'(1)) == CMP_W'(cnt_reg));
        end
        sts.found    = found_reg;
        sts.out_free = out_free;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = M_TDATA_W'({m_count_reg, m_token_reg, m_status_reg});

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> (!m_valid_reg || m_tready))
        else $error("output item overwritten while waiting");

    a_inc_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.cnt_inc |-> (CMP_W'(cnt_reg) < CMP_W'(DEPTH)))
        else $error("insert into full list");

    a_dec_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.cnt_dec |-> (cnt_reg != '0) && found_reg)
        else $error("delete without a matched entry");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.cnt_inc |=> (CMP_W'(cnt_reg) <= CMP_W'(DEPTH)))
        else $error("fill count beyond depth");

endmodule

/* src/ole_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_ctrl
// Command sequencer: decodes each item and steps the datapath through its
// scan, shift, write and output phases.
// ----------------------------------------------------------------------------
module ole_ctrl
    import ole_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  ole_sts_t sts,
    output ole_ctl_t ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_TAIL,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_TAIL,
        S_DEL_END,
        S_RD_ISSUE,
        S_RD_OUT,
        S_STAT
    } state_t;

    state_t      state_reg, state_next;
    ole_status_t st_reg, st_next;

    always_comb begin
        state_next     = state_reg;
        st_next        = st_reg;
        ctl            = '0;
        ctl.out_status = st_reg;
        case (state_reg)
            S_IDLE: begin
                ctl.latch = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.op)
                    OP_FRONT, OP_BACK, OP_POS: begin
                        if (sts.op == OP_POS && sts.pos_zero) begin
                            st_next    = ST_BADPOS;
                            state_next = S_STAT;
                        end else if (sts.op == OP_POS && sts.pos_beyond) begin
                            st_next    = ST_NOPOS;
                            state_next = S_STAT;
                        end else if (sts.full) begin
                            st_next    = ST_FULL;
                            state_next = S_STAT;
                        end else if (sts.has_moves) begin
                            ctl.addr_load = 1'b1;
                            state_next    = S_INS_RD;
                        end else begin
                            state_next = S_INS_PUT;
                        end
                    end
                    OP_DEL: begin
                        if (sts.empty) begin
                            st_next    = ST_EMPTY;
                            state_next = S_STAT;
                        end else begin
                            ctl.addr_load = 1'b1;
                            state_next    = S_DEL_RD;
                        end
                    end
                    OP_RD_FWD, OP_RD_REV: begin
                        if (sts.empty) begin
                            st_next    = ST_EMPTY;
                            state_next = S_STAT;
                        end else begin
                            ctl.addr_load = 1'b1;
                            state_next    = S_RD_ISSUE;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS_RD: begin
                ctl.rd_en     = 1'b1;
                ctl.scan_en   = 1'b1;
                ctl.addr_step = 1'b1;
                if (sts.addr_last) begin
                    state_next = S_INS_TAIL;
                end
            end
            S_INS_TAIL: begin
                ctl.scan_en = 1'b1;
                state_next  = S_INS_PUT;
            end
            S_INS_PUT: begin
                ctl.put_wr  = 1'b1;
                ctl.cnt_inc = 1'b1;
                st_next     = ST_OK;
                state_next  = S_STAT;
            end
            S_DEL_RD: begin
                ctl.rd_en     = 1'b1;
                ctl.scan_en   = 1'b1;
                ctl.addr_step = 1'b1;
                if (sts.addr_last) begin
                    state_next = S_DEL_TAIL;
                end
            end
            S_DEL_TAIL: begin
                ctl.scan_en = 1'b1;
                state_next  = S_DEL_END;
            end
            S_DEL_END: begin
                if (sts.found) begin
                    ctl.cnt_dec = 1'b1;
                    st_next     = ST_OK;
                end else begin
                    st_next = ST_NOTFOUND;
                end
                state_next = S_STAT;
            end
            S_RD_ISSUE: begin
                ctl.rd_en     = 1'b1;
                ctl.addr_step = 1'b1;
                state_next    = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    ctl.out_mem  = 1'b1;
                    if (sts.rd_last) begin
                        state_next = S_IDLE;
                    end else begin
                        ctl.rd_en     = 1'b1;
                        ctl.addr_step = 1'b1;
                    end
                end
            end
            S_STAT: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule
